### rtl/bsm_pkg.sv
// Shared types and constants for the multi-precision schoolbook multiplier.
`timescale 1ns / 1ps
package bsm_pkg;

  localparam int LIMB_W = 32;
  localparam int WORD_W = 2 * LIMB_W;
  localparam int CFG_REG_W = 7;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [CFG_REG_W-1:0] CFG_LIMBS_RESET = 7'd64;

  localparam logic REG_OPERAND_LIMBS = 1'b0;

  typedef struct packed {
    logic step;
    logic first_row;
    logic carry_clear;
    logic carry_write;
    logic read_en;
  } prod_ctrl_t;

endpackage

### rtl/bsm_cfg.sv
// APB register block holding the operand limb count.
`timescale 1ns / 1ps
module bsm_cfg #(
  parameter int MAX_LIMBS = 64,
  parameter int NW = $clog2(MAX_LIMBS + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bsm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bsm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bsm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic                             cfg_wr,
  output logic [NW-1:0]                    n_eff
);
  import bsm_pkg::*;

  logic [CFG_REG_W-1:0] limbs;
  logic                 sel_limbs;

  assign pready    = 1'b1;
  assign sel_limbs = (paddr[2] == REG_OPERAND_LIMBS);
  assign cfg_wr    = psel & penable & pwrite & pready & sel_limbs;

  always_ff @(posedge clk) begin
    if (rst) begin
      limbs <= CFG_LIMBS_RESET;
    end else if (cfg_wr) begin
      limbs <= pwdata[CFG_REG_W-1:0];
    end
  end

  assign prdata = sel_limbs ? {{(APB_DATA_W-CFG_REG_W){1'b0}}, limbs} : '0;

  always_comb begin
    if (limbs == '0) begin
      n_eff = NW'(1);
    end else if (limbs > CFG_REG_W'(MAX_LIMBS)) begin
      n_eff = NW'(MAX_LIMBS);
    end else begin
      n_eff = NW'(limbs);
    end
  end

endmodule

### rtl/bsm_operand_store.sv
// Operand a and b limb memories, written per request, read for the multiply loop.
`timescale 1ns / 1ps
module bsm_operand_store #(
  parameter int MAX_LIMBS = 64,
  parameter int LAW = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [LAW-1:0]            wr_addr,
  input  logic [bsm_pkg::LIMB_W-1:0] a_wdata,
  input  logic [bsm_pkg::LIMB_W-1:0] b_wdata,
  input  logic                      a_rd_en,
  input  logic [LAW-1:0]            a_rd_addr,
  input  logic                      b_rd_en,
  input  logic [LAW-1:0]            b_rd_addr,
  output logic [bsm_pkg::LIMB_W-1:0] a_rdata,
  output logic [bsm_pkg::LIMB_W-1:0] b_rdata
);
  import bsm_pkg::*;

  logic [LIMB_W-1:0] a_mem [MAX_LIMBS];
  logic [LIMB_W-1:0] b_mem [MAX_LIMBS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      a_mem[wr_addr] <= a_wdata;
      b_mem[wr_addr] <= b_wdata;
    end
    if (a_rd_en) begin
      a_rdata <= a_mem[a_rd_addr];
    end
    if (b_rd_en) begin
      b_rdata <= b_mem[b_rd_addr];
    end
  end

endmodule

### rtl/bsm_product_unit.sv
// Product limb memory with the multiply-accumulate pipeline and carry register.
`timescale 1ns / 1ps
module bsm_product_unit #(
  parameter int MAX_LIMBS = 64,
  parameter int PAW = $clog2(2 * MAX_LIMBS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bsm_pkg::prod_ctrl_t        ctrl,
  input  logic [PAW-1:0]             addr,
  input  logic [bsm_pkg::LIMB_W-1:0] a_rdata,
  input  logic [bsm_pkg::LIMB_W-1:0] b_rdata,
  output logic [bsm_pkg::LIMB_W-1:0] p_rdata,
  output logic                       busy
);
  import bsm_pkg::*;

  logic [LIMB_W-1:0] p_mem [2 * MAX_LIMBS];

  logic              s1_valid;
  logic              s1_first;
  logic [PAW-1:0]    s1_addr;
  logic              s2_valid;
  logic [PAW-1:0]    s2_addr;
  logic [WORD_W-1:0] prod;
  logic [LIMB_W-1:0] pv;
  logic [LIMB_W-1:0] carry;
  logic [WORD_W-1:0] sum;

  logic              we;
  logic [PAW-1:0]    wa;
  logic [LIMB_W-1:0] wd;

  assign sum  = prod + WORD_W'(pv) + WORD_W'(carry);
  assign busy = s1_valid | s2_valid;

  always_comb begin
    we = s2_valid | ctrl.carry_write;
    wa = s2_valid ? s2_addr : addr;
    wd = s2_valid ? sum[LIMB_W-1:0] : carry;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      p_mem[wa] <= wd;
    end
    if (ctrl.step | ctrl.read_en) begin
      p_rdata <= p_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= ctrl.step;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= ctrl.first_row;
    s1_addr  <= addr;
    s2_addr  <= s1_addr;
    prod     <= WORD_W'(a_rdata) * WORD_W'(b_rdata);
    pv       <= s1_first ? '0 : p_rdata;
    if (ctrl.carry_clear) begin
      carry <= '0;
    end else if (s2_valid) begin
      carry <= sum[WORD_W-1:LIMB_W];
    end
  end

endmodule

### rtl/bignum_schoolbook_multiplier_unit.sv
// Top level: operand loading, schoolbook sequencer and product word output.
//
//   channel   | dir | handshake           | payload
//   ----------+-----+---------------------+-------------------------------------
//   s_*       | in  | s_tvalid / s_tready | s_tdata: a_limb, b_limb
//   m_*       | out | m_tvalid / m_tready | m_tdata: product_word; m_tlast: last_word
//   apb       | in  | psel, penable       | paddr, pwdata, prdata (operand_limbs)
//
// Loading takes one request per cycle; the Nth request starts the multiply.
// The multiply runs N rows through one 32x32 multiplier, with one read port and
// one write port on the product memory.
// Each product word then takes two limb reads (RDLO, RDHI) and an emit state that waits out output stalls.
// Reset is synchronous; no clearing pass, the first row ignores old product limbs.
`timescale 1ns / 1ps
module bignum_schoolbook_multiplier_unit #(
  parameter int MAX_LIMBS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [63:0]                      s_tdata,   // [31:0] a_limb, [63:32] b_limb
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [63:0]                      m_tdata,   // [63:0] product_word
  output logic                             m_tlast,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bsm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bsm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bsm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import bsm_pkg::*;

  localparam int NW  = $clog2(MAX_LIMBS + 1);
  localparam int LAW = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
  localparam int PAW = $clog2(2 * MAX_LIMBS);

  typedef enum logic [6:0] {
    ST_LOAD  = 7'b0000001,
    ST_BLOAD = 7'b0000010,
    ST_RUN   = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_RDLO  = 7'b0010000,
    ST_RDHI  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  state_t            state;
  logic [LAW-1:0]    cnt;
  logic [LAW-1:0]    row;
  logic [LAW-1:0]    col;
  logic [LAW-1:0]    word;
  logic [LIMB_W-1:0] lo;

  logic              cfg_wr;
  logic [NW-1:0]     n_eff;
  logic [NW-1:0]     n_dec;
  logic [LAW-1:0]    n_m1;
  logic              in_acc;
  logic              out_free;
  logic              busy;
  prod_ctrl_t        ctrl;
  logic [PAW-1:0]    p_addr;
  logic [LIMB_W-1:0] a_rdata;
  logic [LIMB_W-1:0] b_rdata;
  logic [LIMB_W-1:0] p_rdata;

  assign n_dec    = n_eff - NW'(1);
  assign n_m1     = n_dec[LAW-1:0];
  assign s_tready = (state == ST_LOAD);
  assign in_acc   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;

  bsm_cfg #(
    .MAX_LIMBS(MAX_LIMBS),
    .NW       (NW)
  ) u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_wr (cfg_wr),
    .n_eff  (n_eff)
  );

  bsm_operand_store #(
    .MAX_LIMBS(MAX_LIMBS),
    .LAW      (LAW)
  ) u_operands (
    .clk      (clk),
    .wr_en    (in_acc),
    .wr_addr  (cnt),
    .a_wdata  (s_tdata[LIMB_W-1:0]),
    .b_wdata  (s_tdata[WORD_W-1:LIMB_W]),
    .a_rd_en  (state == ST_RUN),
    .a_rd_addr(col),
    .b_rd_en  (state == ST_BLOAD),
    .b_rd_addr(row),
    .a_rdata  (a_rdata),
    .b_rdata  (b_rdata)
  );

  always_comb begin
    ctrl.step        = (state == ST_RUN);
    ctrl.first_row   = (row == '0);
    ctrl.carry_clear = (state == ST_BLOAD);
    ctrl.carry_write = (state == ST_DRAIN) & ~busy;
    ctrl.read_en     = (state == ST_RDLO) | (state == ST_RDHI);
    case (state)
      ST_RUN:   p_addr = PAW'(row) + PAW'(col);
      ST_DRAIN: p_addr = PAW'(row) + PAW'(n_eff);
      ST_RDLO:  p_addr = PAW'({word, 1'b0});
      ST_RDHI:  p_addr = PAW'({word, 1'b1});
      default:  p_addr = '0;
    endcase
  end

  bsm_product_unit #(
    .MAX_LIMBS(MAX_LIMBS),
    .PAW      (PAW)
  ) u_product (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .addr   (p_addr),
    .a_rdata(a_rdata),
    .b_rdata(b_rdata),
    .p_rdata(p_rdata),
    .busy   (busy)
  );

  always_ff @(posedge clk) begin
    if (state == ST_RDHI) begin
      lo <= p_rdata;
    end
    if ((state == ST_EMIT) && out_free) begin
      m_tdata <= {p_rdata, lo};
      m_tlast <= (word == n_m1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      cnt      <= '0;
      row      <= '0;
      col      <= '0;
      word     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == ST_EMIT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (cfg_wr) begin
            cnt <= '0;
          end else if (in_acc) begin
            if (cnt == n_m1) begin
              cnt   <= '0;
              row   <= '0;
              state <= ST_BLOAD;
            end else begin
              cnt <= cnt + LAW'(1);
            end
          end
        end
        ST_BLOAD: begin
          col   <= '0;
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (col == n_m1) begin
            state <= ST_DRAIN;
          end else begin
            col <= col + LAW'(1);
          end
        end
        ST_DRAIN: begin
          if (!busy) begin
            if (row == n_m1) begin
              word  <= '0;
              state <= ST_RDLO;
            end else begin
              row   <= row + LAW'(1);
              state <= ST_BLOAD;
            end
          end
        end
        ST_RDLO: begin
          state <= ST_RDHI;
        end
        ST_RDHI: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (word == n_m1) begin
              state <= ST_LOAD;
            end else begin
              word  <= word + LAW'(1);
              state <= ST_RDLO;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

### rtl/bsm_checker.sv
// Port-level checks for the schoolbook multiplier, bound to the top level.
`timescale 1ns / 1ps
module bsm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [63:0]                    m_tdata,
  input logic                           m_tlast,
  input logic                           psel,
  input logic                           pwrite,
  input logic [bsm_pkg::APB_ADDR_W-1:0] paddr,
  input logic [bsm_pkg::APB_DATA_W-1:0] prdata
);
  import bsm_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  a_no_load_mid_product: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("request taken while product words pending");

  a_read_limbs_width: assert property (@(posedge clk) disable iff (rst)
    psel && !pwrite && (paddr[2] == REG_OPERAND_LIMBS) |-> prdata[APB_DATA_W-1:CFG_REG_W] == '0)
    else $error("limb count read back out of range");

endmodule

bind bignum_schoolbook_multiplier_unit bsm_checker u_bsm_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast),
  .psel    (psel),
  .pwrite  (pwrite),
  .paddr   (paddr),
  .prdata  (prdata)
);

### verif/testbench.sv
// Self-checking testbench for the schoolbook multiplier: limb stream in, product words out, APB setup.
`timescale 1ns / 1ps
module testbench;
  import bsm_pkg::*;

  localparam int MAX_LIMBS = 64;
  localparam int ITEM_TARGET = 470;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [LIMB_W-1:0] LIMB_MAX = 32'hFFFF_FFFF;
  localparam logic [APB_ADDR_W-1:0] LIMBS_ADDR = APB_ADDR_W'(4 * REG_OPERAND_LIMBS);
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = APB_ADDR_W'(4);

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              last;
  } product_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [63:0]           s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [63:0]           m_tdata;
  logic                  m_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic [63:0]       limb_pairs_pending[$];
  product_word_t     product_words_due[$];
  logic [LIMB_W-1:0] a_limbs[MAX_LIMBS];
  logic [LIMB_W-1:0] b_limbs[MAX_LIMBS];
  logic [CFG_REG_W-1:0] limbs_cfg = CFG_LIMBS_RESET;
  int                limbs_loaded = 0;
  int                pairs_queued = 0;
  int                pairs_accepted = 0;
  int                words_checked = 0;
  int                settings_written = 0;
  int                errors = 0;
  int                send_gap = 0;
  int                stall_left = 0;
  int                cycle_count = 0;
  bit                no_idle = 1'b0;

  bignum_schoolbook_multiplier_unit #(.MAX_LIMBS(MAX_LIMBS)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int active_limbs();
    int n;
    n = limbs_cfg;
    if (n == 0) n = 1;
    if (n > MAX_LIMBS) n = MAX_LIMBS;
    return n;
  endfunction

  // Store one limb pair; on the last pair of an operand form the full product.
  task automatic load_limb_pair(input logic [63:0] data);
    logic [LIMB_W-1:0] prod[2*MAX_LIMBS];
    logic [63:0]       acc;
    logic [63:0]       carry;
    product_word_t     pw;
    int                n;
    int                slot;
    int                i;
    int                j;
    int                k;
    n = active_limbs();
    slot = limbs_loaded;
    if (slot >= n) slot = 0;
    a_limbs[slot] = data[31:0];
    b_limbs[slot] = data[63:32];
    slot++;
    if (slot < n) begin
      limbs_loaded = slot;
    end else begin
      limbs_loaded = 0;
      for (k = 0; k < 2 * MAX_LIMBS; k++) prod[k] = '0;
      for (i = 0; i < n; i++) begin
        carry = '0;
        for (j = 0; j < n; j++) begin
          acc = {32'b0, b_limbs[i]} * {32'b0, a_limbs[j]} + {32'b0, prod[i+j]} + carry;
          prod[i+j] = acc[31:0];
          carry = acc >> 32;
        end
        prod[i+n] = prod[i+n] + carry[31:0];
      end
      for (k = 0; k < n; k++) begin
        pw.word = {prod[2*k+1], prod[2*k]};
        pw.last = (k == n - 1);
        product_words_due.push_back(pw);
      end
    end
  endtask

  function automatic int pick_pause();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 48);
  endfunction

  function automatic logic [LIMB_W-1:0] rand_limb();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return LIMB_MAX;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return LIMB_MAX ^ (32'h1 << $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin
    logic [63:0] next_data;
    logic        next_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        load_limb_pair(s_tdata);
        pairs_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        next_valid = 1'b0;
        next_data = s_tdata;
        if (send_gap > 0) begin
          send_gap--;
        end else if (limb_pairs_pending.size() > 0) begin
          next_data = limb_pairs_pending.pop_front();
          next_valid = 1'b1;
          send_gap = pick_pause();
        end
        s_tvalid <= next_valid;
        s_tdata <= next_data;
      end
    end
  end

  always @(posedge clk) begin
    product_word_t due;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (product_words_due.size() == 0) begin
          $error("product_word: none expected, got %h", m_tdata);
          errors++;
        end else begin
          due = product_words_due.pop_front();
          if (m_tdata !== due.word) begin
            $error("product_word: expected %h, actual %h", due.word, m_tdata);
            errors++;
          end
          if (m_tlast !== due.last) begin
            $error("last_word: expected %b, actual %b", due.last, m_tlast);
            errors++;
          end
          words_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall_left = pick_pause();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == LIMBS_ADDR) begin
      limbs_cfg = value[CFG_REG_W-1:0];
      limbs_loaded = 0;
    end
  endtask

  task automatic check_limbs_reg();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= LIMBS_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[CFG_REG_W-1:0] !== limbs_cfg) begin
      $error("operand_limbs: expected %0d, actual %0d", limbs_cfg, prdata[CFG_REG_W-1:0]);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limbs(input int unsigned value);
    apb_write(LIMBS_ADDR, APB_DATA_W'(value));
    check_limbs_reg();
    settings_written++;
  endtask

  task automatic queue_pair(input logic [LIMB_W-1:0] a, input logic [LIMB_W-1:0] b);
    limb_pairs_pending.push_back({b, a});
    pairs_queued++;
  endtask

  task automatic queue_pairs(input int count);
    int k;
    for (k = 0; k < count; k++) queue_pair(rand_limb(), rand_limb());
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pairs_accepted != pairs_queued || product_words_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int phase;
    int ops;
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // zero limb count acts as one limb
    set_limbs(0);
    queue_pair('0, '0);
    queue_pair(LIMB_MAX, LIMB_MAX);
    queue_pair(LIMB_MAX, '0);
    queue_pair('0, LIMB_MAX);
    queue_pair(32'h1, LIMB_MAX);
    wait_drained();
    set_limbs(1);
    queue_pair(32'h8000_0000, 32'h8000_0000);
    queue_pair(LIMB_MAX, 32'h1);
    wait_drained();
    set_limbs(2);
    queue_pair(LIMB_MAX, LIMB_MAX);
    queue_pair(LIMB_MAX, LIMB_MAX);
    queue_pair('0, LIMB_MAX);
    queue_pair('0, LIMB_MAX);
    wait_drained();
    // unmapped address must leave the limb count alone
    apb_write(UNMAPPED_ADDR, 32'h5);
    check_limbs_reg();
    queue_pair(32'h1, LIMB_MAX);
    queue_pair(LIMB_MAX, 32'h1);
    wait_drained();
    // rewrite mid-operand: drop loaded limbs and restart
    set_limbs(3);
    queue_pairs(2);
    wait_drained();
    set_limbs(3);
    queue_pairs(3);
    wait_drained();
    set_limbs(4);
    queue_pairs(3);
    wait_drained();
    set_limbs(2);
    queue_pairs(2);
    wait_drained();

    phase = 0;
    while (pairs_queued < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if (phase == 1) set_limbs(MAX_LIMBS);
      else if (phase == 4) set_limbs(127);
      else set_limbs($urandom_range(0, 12));
      n = active_limbs();
      ops = (n == MAX_LIMBS) ? 1 : $urandom_range(2, 6);
      repeat (ops) begin
        queue_pairs(n);
        if ($urandom_range(0, 4) == 0) wait_drained();
      end
      if (n > 1 && $urandom_range(0, 3) == 0) queue_pairs($urandom_range(1, n - 1));
      wait_drained();
      phase++;
    end
    no_idle = 1'b0;
    wait_drained();

    $display("Sent %0d limb pairs under %0d limb-count settings (1 to 64 limbs, zero and",
             pairs_accepted, settings_written);
    $display("saturating counts, mid-operand rewrites); checked %0d product words.", words_checked);
    if (errors == 0 && product_words_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
